### src/tkpk_pkg.sv
// Shared constants, types and state codes of the top-K price keeper.
package tkpk_pkg;

   // Number of entries that the store keeps.
   localparam int BAG_SIZE = 8;

   // Width of an entry index.
   localparam int IDX_W = (BAG_SIZE > 1) ? $clog2(BAG_SIZE) : 1;

   // Width of a count that can hold BAG_SIZE itself.
   localparam int CNT_W = $clog2(BAG_SIZE + 1);

   // Width of the tag and price fields.
   localparam int FIELD_W = 16;

   // A stored entry is the tag above the price.
   localparam int ENTRY_W = 2 * FIELD_W;

   // Reset value of the reject price register.
   localparam logic [FIELD_W-1:0] REJECT_RESET = 16'd9999;

   // Operation codes of the request word.
   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register word indexes on the configuration port.
   localparam logic REG_REJECT = 1'b0;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [FIELD_W-1:0] field_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_OFF_WR = 5'b00100,
      S_SWAP_A = 5'b01000,
      S_SWAP_B = 5'b10000
   } state_type;

endpackage

### src/top_k_price_keeper.sv
// Top level of the top-K price keeper: store control, sort sequencer and register port.
//
//   Channel   Ports                                        Handshake
//   -------   ------------------------------------------   ---------------------------------
//   request   req_op, req_item_tag, req_price              taken when start and not busy
//   result    rsp_out_tag, rsp_out_price, rsp_last         one cycle, marked by rsp_valid
//   config    psel, penable, pwrite, paddr, pwdata,        written on the access phase,
//             prdata, pready                               pready always high
//
// An offer that is rejected, or that is appended while the store is not full, is taken
// in idle and the block stays ready. An offer into a full store scans every entry through
// the single read port of the entry RAM, so busy stays high for the scan and the write.
// A drain of F entries sorts in place: pass s scans F - s entries and then swaps in the
// states S_SWAP_A and S_SWAP_B; a drain of an empty store leaves the block idle. Each
// word of the drain appears on the result ports for exactly one cycle, emitted at the
// swap that fixes its position, so the receiver cannot stall the block.
// Reset is synchronous and clears the fill count, the state and the reject price (to
// 9999); the entry RAM is not cleared, since only filled entries are ever read.
module top_k_price_keeper (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic [15:0]             req_item_tag,
   input  logic [15:0]             req_price,

   output logic                    rsp_valid,
   output logic [15:0]             rsp_out_tag,
   output logic [15:0]             rsp_out_price,
   output logic                    rsp_last,

   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   tkpk_pkg::state_type  state_ff, state_in;
   tkpk_pkg::cnt_type    fill_count_ff, fill_count_in;
   tkpk_pkg::field_type  reject_price_ff, reject_price_in;

   // Mode of the current scan: set for a drain, clear for an offer into a full store.
   logic                 drain_ff, drain_in;
   // Head of the unsorted tail during a drain; zero for an offer scan.
   tkpk_pkg::cnt_type    base_ff, base_in;
   // Next RAM address to read, and the read that is in flight.
   tkpk_pkg::cnt_type    rd_idx_ff, rd_idx_in;
   logic                 pend_ff, pend_in;
   tkpk_pkg::idx_type    pend_idx_ff, pend_idx_in;
   // Best entry found so far: the minimum for an offer, the maximum for a drain.
   tkpk_pkg::field_type  best_price_ff, best_price_in;
   tkpk_pkg::field_type  best_tag_ff, best_tag_in;
   tkpk_pkg::idx_type    best_idx_ff, best_idx_in;
   // Entry at the head of the tail, which the swap moves to where the best one was.
   logic [tkpk_pkg::ENTRY_W-1:0] first_ff, first_in;
   // Offered item held while the full store is scanned.
   tkpk_pkg::field_type  tag_ff, tag_in;
   tkpk_pkg::field_type  price_ff, price_in;

   // Result word register.
   logic                 rsp_valid_ff, rsp_valid_in;
   tkpk_pkg::field_type  rsp_tag_ff, rsp_tag_in;
   tkpk_pkg::field_type  rsp_price_ff, rsp_price_in;
   logic                 rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------------
   // Entry RAM: tag in the upper half, price in the lower half.
   // ------------------------------------------------------------------
   logic                          ram_we;
   tkpk_pkg::idx_type             ram_waddr;
   logic [tkpk_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [tkpk_pkg::ENTRY_W-1:0]  ram_rdata;
   tkpk_pkg::field_type           rd_tag;
   tkpk_pkg::field_type           rd_price;

   tkpk_ram #(
      .WIDTH (tkpk_pkg::ENTRY_W),
      .DEPTH (tkpk_pkg::BAG_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx_ff[tkpk_pkg::IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_tag   = ram_rdata[tkpk_pkg::ENTRY_W-1:tkpk_pkg::FIELD_W];
   assign rd_price = ram_rdata[tkpk_pkg::FIELD_W-1:0];

   // ------------------------------------------------------------------
   // Handshake helpers
   // ------------------------------------------------------------------
   logic                accept;
   logic                cfg_write;
   logic                reg_sel;
   tkpk_pkg::cnt_type   last_idx;
   logic                store_full;

   assign busy       = (state_ff != tkpk_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign pready     = 1'b1;
   assign reg_sel    = (paddr[2] == tkpk_pkg::REG_REJECT);
   assign cfg_write  = psel && penable && pwrite && pready;
   assign last_idx   = fill_count_ff - tkpk_pkg::cnt_type'(1);
   assign store_full = (fill_count_ff == tkpk_pkg::cnt_type'(tkpk_pkg::BAG_SIZE));

   // The register reads back zero-extended; other word addresses read as zero.
   assign prdata = reg_sel ? {16'b0, reject_price_ff} : 32'b0;

   always_comb begin
      reject_price_in = reject_price_ff;
      if (cfg_write && reg_sel) begin
         reject_price_in = pwdata[15:0];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      drain_in      = drain_ff;
      base_in       = base_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      best_price_in = best_price_ff;
      best_tag_in   = best_tag_ff;
      best_idx_in   = best_idx_ff;
      first_in      = first_ff;
      tag_in        = tag_ff;
      price_in      = price_ff;
      rsp_valid_in  = 1'b0;
      rsp_tag_in    = rsp_tag_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = best_idx_ff;
      ram_wdata     = {best_tag_ff, best_price_ff};

      case (state_ff)
         tkpk_pkg::S_IDLE: begin
            if (accept) begin
               tag_in    = req_item_tag;
               price_in  = req_price;
               base_in   = '0;
               rd_idx_in = '0;
               if (req_op == tkpk_pkg::OP_DRAIN) begin
                  // An empty store drains to nothing.
                  drain_in = 1'b1;
                  if (fill_count_ff != '0) begin
                     state_in = tkpk_pkg::S_SCAN;
                  end
               end else if (req_price != reject_price_ff) begin
                  drain_in = 1'b0;
                  if (store_full) begin
                     state_in = tkpk_pkg::S_SCAN;
                  end else begin
                     // Append at the fill count; the write lands before any later read.
                     ram_we        = 1'b1;
                     ram_waddr     = fill_count_ff[tkpk_pkg::IDX_W-1:0];
                     ram_wdata     = {req_item_tag, req_price};
                     fill_count_in = fill_count_ff + tkpk_pkg::cnt_type'(1);
                  end
               end
            end
         end

         tkpk_pkg::S_SCAN: begin
            // Issue one read a cycle up to the fill count.
            if (rd_idx_ff < fill_count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[tkpk_pkg::IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + tkpk_pkg::cnt_type'(1);
            end
            // Compare the entry that arrives from the previous read.
            if (pend_ff) begin
               if (tkpk_pkg::cnt_type'(pend_idx_ff) == base_ff) begin
                  best_price_in = rd_price;
                  best_tag_in   = rd_tag;
                  best_idx_in   = pend_idx_ff;
                  first_in      = ram_rdata;
               end else if (drain_ff ? (rd_price > best_price_ff)
                                     : (rd_price < best_price_ff)) begin
                  // Strict compare keeps the first entry found among equals.
                  best_price_in = rd_price;
                  best_tag_in   = rd_tag;
                  best_idx_in   = pend_idx_ff;
               end
               if (tkpk_pkg::cnt_type'(pend_idx_ff) == last_idx) begin
                  pend_in  = 1'b0;
                  state_in = drain_ff ? tkpk_pkg::S_SWAP_A : tkpk_pkg::S_OFF_WR;
               end
            end
         end

         tkpk_pkg::S_OFF_WR: begin
            // Replace the first minimum only when the offer is strictly greater.
            ram_we    = (best_price_ff < price_ff);
            ram_waddr = best_idx_ff;
            ram_wdata = {tag_ff, price_ff};
            state_in  = tkpk_pkg::S_IDLE;
         end

         tkpk_pkg::S_SWAP_A: begin
            // The largest entry of the tail takes the head; it is final, so emit it.
            ram_we       = 1'b1;
            ram_waddr    = base_ff[tkpk_pkg::IDX_W-1:0];
            ram_wdata    = {best_tag_ff, best_price_ff};
            rsp_valid_in = 1'b1;
            rsp_tag_in   = best_tag_ff;
            rsp_price_in = best_price_ff;
            rsp_last_in  = (base_ff == last_idx);
            state_in     = tkpk_pkg::S_SWAP_B;
         end

         tkpk_pkg::S_SWAP_B: begin
            // The old head goes where the largest entry was.
            ram_we    = 1'b1;
            ram_waddr = best_idx_ff;
            ram_wdata = first_ff;
            base_in   = base_ff + tkpk_pkg::cnt_type'(1);
            rd_idx_in = base_ff + tkpk_pkg::cnt_type'(1);
            if (base_ff == last_idx) begin
               state_in = tkpk_pkg::S_IDLE;
            end else begin
               state_in = tkpk_pkg::S_SCAN;
            end
         end

         default: begin
            state_in = tkpk_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Register update
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tkpk_pkg::S_IDLE;
         fill_count_ff   <= '0;
         reject_price_ff <= tkpk_pkg::REJECT_RESET;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         drain_ff        <= 1'b0;
         base_ff         <= '0;
         rd_idx_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         fill_count_ff   <= fill_count_in;
         reject_price_ff <= reject_price_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
         drain_ff        <= drain_in;
         base_ff         <= base_in;
         rd_idx_ff       <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      best_price_ff <= best_price_in;
      best_tag_ff   <= best_tag_in;
      best_idx_ff   <= best_idx_in;
      first_ff      <= first_in;
      tag_ff        <= tag_in;
      price_ff      <= price_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_out_price = rsp_price_ff;
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   // A result word only leaves during a drain, so the block is still busy.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result word shown while idle");

   // The fill count never passes the store size.
   assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= tkpk_pkg::cnt_type'(tkpk_pkg::BAG_SIZE))
      else $error("fill count beyond store size");

   // A scan never runs over an empty store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkpk_pkg::S_SCAN) |-> (fill_count_ff != '0))
      else $error("scan of an empty store");

   // The last word of a drain returns the block to idle in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("block still busy after the last word");
`endif

endmodule

### src/tkpk_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tkpk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/top_k_price_keeper_tb.sv
// Self-checking testbench of the top-K price keeper: offer/drain stimulus, scoreboard, checks.
`timescale 1ns / 1ps

module top_k_price_keeper_tb;

   // Byte address of each register word on the configuration port. The spare address
   // decodes to a word index that holds no register, so writes to it must be ignored.
   localparam logic [2:0] ADDR_REJECT = 3'(4 * tkpk_pkg::REG_REJECT);
   localparam logic [2:0] ADDR_SPARE  = 3'd4;

   // Cycles to let pass after the last expected word before touching the register,
   // covering an offer into a full store, which produces no word at all.
   localparam int SETTLE_CYCLES = 2 * tkpk_pkg::BAG_SIZE + 8;

   // Longest wait for the expected words to drain out.
   localparam int QUIET_LIMIT = 20000;

   // One request word as the sender sees it.
   typedef struct packed {
      logic                tag_op;
      tkpk_pkg::field_type tag;
      tkpk_pkg::field_type price;
   } request_word_type;

   // One result word of a drain run.
   typedef struct packed {
      tkpk_pkg::field_type tag;
      tkpk_pkg::field_type price;
      logic                last;
   } ranked_word_type;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   logic        busy;
   logic        req_op  = tkpk_pkg::OP_OFFER;
   logic [15:0] req_item_tag = '0;
   logic [15:0] req_price    = '0;
   logic        rsp_valid;
   logic [15:0] rsp_out_tag;
   logic [15:0] rsp_out_price;
   logic        rsp_last;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   top_k_price_keeper dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_item_tag  (req_item_tag),
      .req_price     (req_price),
      .rsp_valid     (rsp_valid),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_price (rsp_out_price),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Words waiting to be sent, the word currently offered on the request port, and the
   // ranked words that the drains accepted so far are still owed.
   request_word_type pending_requests[$];
   request_word_type in_flight;
   ranked_word_type  owed_ranking[$];

   // Percentage of cycles in which the sender leaves the request port idle.
   int idle_pct = 0;

   int fault_count    = 0;
   int requests_taken = 0;
   int drains_taken   = 0;
   int words_checked  = 0;
   int reject_writes  = 0;

   // Shadow copy of the keeper: the store of (tag, price) entries, its fill level and
   // the reject price register.
   tkpk_pkg::field_type shadow_price[tkpk_pkg::BAG_SIZE];
   tkpk_pkg::field_type shadow_tag[tkpk_pkg::BAG_SIZE];
   int                  shadow_fill = 0;
   tkpk_pkg::field_type shadow_reject = tkpk_pkg::REJECT_RESET;

   // Only the first ten faults are printed; the rest are just counted.
   task automatic report_fault(input string msg);
      if (fault_count < 10) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      fault_count++;
   endtask

   // Applies one accepted request to the shadow store. An offer updates the store; a
   // drain sorts it in place, descending, and queues one ranked word per entry.
   task automatic apply_request(input request_word_type w);
      int                  low_idx;
      int                  best;
      tkpk_pkg::field_type low;
      tkpk_pkg::field_type big;
      tkpk_pkg::field_type tmp_p;
      tkpk_pkg::field_type tmp_t;
      ranked_word_type     r;
      if (w.tag_op == tkpk_pkg::OP_OFFER) begin
         if (w.price != shadow_reject) begin
            if (shadow_fill < tkpk_pkg::BAG_SIZE) begin
               shadow_price[shadow_fill] = w.price;
               shadow_tag[shadow_fill]   = w.tag;
               shadow_fill++;
            end else begin
               // Full store: the first entry holding the minimum is the victim, and it
               // only goes when the new price is strictly greater.
               low     = shadow_price[0];
               low_idx = 0;
               for (int i = 0; i < tkpk_pkg::BAG_SIZE; i++) begin
                  if (shadow_price[i] < low) begin
                     low     = shadow_price[i];
                     low_idx = i;
                  end
               end
               if (low < w.price) begin
                  shadow_price[low_idx] = w.price;
                  shadow_tag[low_idx]   = w.tag;
               end
            end
         end
      end else begin
         drains_taken++;
         // Selection sort with swap: the first strictly largest of the tail moves to
         // its front, which fixes the order that equal prices come out in.
         for (int s = 0; s < shadow_fill; s++) begin
            best = s;
            big  = shadow_price[s];
            for (int j = s; j < shadow_fill; j++) begin
               if (shadow_price[j] > big) begin
                  big  = shadow_price[j];
                  best = j;
               end
            end
            tmp_p = shadow_price[s];
            tmp_t = shadow_tag[s];
            shadow_price[s]    = shadow_price[best];
            shadow_tag[s]      = shadow_tag[best];
            shadow_price[best] = tmp_p;
            shadow_tag[best]   = tmp_t;
         end
         for (int k = 0; k < shadow_fill; k++) begin
            r.tag   = shadow_tag[k];
            r.price = shadow_price[k];
            r.last  = (k + 1 == shadow_fill);
            owed_ranking.push_back(r);
         end
      end
   endtask

   // Driver. A word is taken at the edge where start is high and busy is low; it is then
   // applied to the shadow store, and the next word is offered or the port goes idle.
   // While busy holds the word off, the port keeps it unchanged.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(in_flight);
            requests_taken++;
         end
         if (start && busy) begin
            // Held off: the same word stays on the port.
         end else if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            in_flight = pending_requests.pop_front();
            start        <= 1'b1;
            req_op       <= in_flight.tag_op;
            req_item_tag <= in_flight.tag;
            req_price    <= in_flight.price;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. Every result word is compared with the oldest word still owed.
   always @(posedge clock) begin
      ranked_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (owed_ranking.size() == 0) begin
            report_fault($sformatf("unexpected word tag %h price %h last %b",
                                   rsp_out_tag, rsp_out_price, rsp_last));
         end else begin
            want = owed_ranking.pop_front();
            words_checked++;
            if (rsp_out_tag !== want.tag || rsp_out_price !== want.price
                || rsp_last !== want.last) begin
               report_fault($sformatf(
                  "word %0d: expected tag %h price %h last %b, got tag %h price %h last %b",
                  words_checked, want.tag, want.price, want.last,
                  rsp_out_tag, rsp_out_price, rsp_last));
            end
         end
      end
   end

   function automatic request_word_type offer_word(input tkpk_pkg::field_type tag,
                                                   input tkpk_pkg::field_type price);
      request_word_type w;
      w.tag_op = tkpk_pkg::OP_OFFER;
      w.tag    = tag;
      w.price  = price;
      return w;
   endfunction

   // A drain carries random tag and price bits, which the block must ignore.
   function automatic request_word_type drain_word();
      request_word_type w;
      w.tag_op = tkpk_pkg::OP_DRAIN;
      w.tag    = tkpk_pkg::field_type'($urandom);
      w.price  = tkpk_pkg::field_type'($urandom);
      return w;
   endfunction

   // Random request: mostly offers, with prices drawn so that ties with the store's
   // minimum, the reject price and the field extremes all come up often.
   function automatic request_word_type random_word();
      tkpk_pkg::field_type price;
      int                  pick;
      if ($urandom_range(0, 9) == 0) begin
         return drain_word();
      end
      pick = $urandom_range(0, 9);
      case (pick)
         0:       price = shadow_reject;
         1, 2, 3: price = tkpk_pkg::field_type'($urandom_range(0, 15));
         4:       price = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         5:       price = shadow_reject + tkpk_pkg::field_type'($urandom_range(0, 2)) - 16'd1;
         default: price = tkpk_pkg::field_type'($urandom);
      endcase
      return offer_word(tkpk_pkg::field_type'($urandom), price);
   endfunction

   // Blocks until every word has been taken and every owed result has arrived, then
   // lets the block settle; reaching the limit, or an owed word left over after that, is a fault.
   // The state is looked at mid-cycle, after the driver and the block have both moved.
   task automatic wait_quiet();
      int guard;
      guard = 0;
      while ((pending_requests.size() != 0 || start || busy !== 1'b0
              || owed_ranking.size() != 0) && guard < QUIET_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= QUIET_LIMIT) begin
         report_fault("block never went quiet");
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_ranking.size() != 0) begin
         report_fault($sformatf("%0d ranked words never arrived", owed_ranking.size()));
         owed_ranking.delete();
      end
   endtask

   // Register write: setup cycle, then access cycle; pready is always high, so the
   // write lands at the edge that ends the access cycle.
   task automatic csr_write(input logic [2:0] addr, input tkpk_pkg::field_type value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_REJECT) begin
         shadow_reject = value;
         reject_writes++;
      end
   endtask

   // Reads the reject price back and checks it against the shadow register.
   task automatic csr_check_reject();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_REJECT;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== shadow_reject) begin
         report_fault($sformatf("reject price read back %h, expected %h",
                                prdata[15:0], shadow_reject));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Main sequence: reset, a directed part under the reset reject price, then random
   // phases, each under its own reject price and its own sender idle rate.
   initial begin
      tkpk_pkg::field_type phase_reject[5];
      int                  phase_idle[5];
      phase_reject = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000};
      phase_reject[2] = tkpk_pkg::field_type'($urandom);
      phase_idle   = '{0, 63, 35, 63, 0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_reject();

      // Directed part. A drain of the empty store must emit nothing, an offer at the
      // reject price is dropped, then the store fills with the field extremes and
      // repeated minimum prices.
      pending_requests.push_back(drain_word());
      pending_requests.push_back(offer_word(16'h1234, tkpk_pkg::REJECT_RESET));
      pending_requests.push_back(offer_word(16'h0000, 16'h0000));
      pending_requests.push_back(offer_word(16'hFFFF, 16'hFFFF));
      pending_requests.push_back(offer_word(16'h0001, 16'd50));
      pending_requests.push_back(offer_word(16'h0002, 16'd50));
      pending_requests.push_back(offer_word(16'h0003, 16'd200));
      pending_requests.push_back(offer_word(16'h0004, 16'd50));
      pending_requests.push_back(offer_word(16'h0005, tkpk_pkg::REJECT_RESET - 16'd1));
      pending_requests.push_back(offer_word(16'h0006, tkpk_pkg::REJECT_RESET + 16'd1));
      // Store is full now. Equal to the minimum leaves it unchanged; greater replaces
      // the first minimum; a reject-price offer stays dropped even though it is larger.
      pending_requests.push_back(offer_word(16'hAAAA, 16'h0000));
      pending_requests.push_back(offer_word(16'hBBBB, 16'd50));
      pending_requests.push_back(offer_word(16'hCCCC, 16'd50));
      pending_requests.push_back(offer_word(16'hDDDD, 16'd51));
      pending_requests.push_back(offer_word(16'h5555, tkpk_pkg::REJECT_RESET));
      pending_requests.push_back(drain_word());
      // A second drain sees the already sorted store, and offers go on from there.
      pending_requests.push_back(drain_word());
      pending_requests.push_back(offer_word(16'hEEEE, 16'd60));
      pending_requests.push_back(offer_word(16'h7777, 16'd10));
      pending_requests.push_back(drain_word());
      wait_quiet();

      // A write to a word index that holds no register must leave the reject price as is.
      csr_write(ADDR_SPARE, 16'h0042);
      csr_check_reject();

      for (int p = 0; p < 5; p++) begin
         csr_write(ADDR_REJECT, phase_reject[p]);
         csr_check_reject();
         idle_pct = phase_idle[p];
         for (int n = 0; n < 50; n++) begin
            pending_requests.push_back(random_word());
         end
         // The predictor draws random prices from the shadow reject price, which does
         // not change within a phase, so the whole phase can be queued up front.
         wait_quiet();
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d requests (%0d drains), %0d ranked words checked,",
               requests_taken, drains_taken, words_checked);
      $display("over %0d reject price settings and sender idle rates of 0, 35 and 63 percent.",
               reject_writes + 1);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
